[rtl/ohtn_pkg.sv]
// ----------------------------------------------------------------------------
// ohtn_pkg
// Shared types, constants and hash functions of the hash tree node unit.
// ----------------------------------------------------------------------------
package ohtn_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
  localparam int unsigned DIG_IDX_W  = 4;
  localparam int unsigned BIT_CNT_W  = 5;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;

  // Work handed from the front part to the back part on a finish request.
  typedef struct packed {
    logic [HASH_W-1:0] node_h;
    logic [HASH_W-1:0] left_h;
    logic [HASH_W-1:0] right_h;
    logic              has_left;
    logic              has_right;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_FOLD,
    BK_FINAL,
    BK_EMIT
  } back_state_t;

  // One byte step of the one-at-a-time hash.
  function automatic logic [HASH_W-1:0] oaat_mix(input logic [HASH_W-1:0] acc,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] a;
    a = acc + {{(HASH_W-8){1'b0}}, b};
    a = a + (a << 10);
    a = a ^ (a >> 6);
    return a;
  endfunction

  // Final avalanche of the one-at-a-time hash.
  function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] acc);
    logic [HASH_W-1:0] a;
    a = acc + (acc << 3);
    a = a ^ (a >> 11);
    a = a + (a << 15);
    return a;
  endfunction

  // One shift-and-add-3 step of binary to BCD conversion.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = bcd[i*4 +: 4];
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      adj[i*4 +: 4] = d;
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

[rtl/oaat_hash_tree_node_unit.sv]
// ----------------------------------------------------------------------------
// oaat_hash_tree_node_unit
// One node of a hash tree built on the one-at-a-time hash.
// ----------------------------------------------------------------------------
// The input side is a queue: a request is taken when in_push is high and
// in_full is low. A data request folds in_data_byte into the running hash
// and gives no result. A finish request mixes the running hash into the
// node hash, clears the running hash and hands a job to the back part.
// The result side is a queue too: out_node_hash is valid while out_empty is
// low and is taken when out_pop is high.
// Data requests go in at one per cycle while in_full is low. A finish
// request for a leaf goes through the queue and the back part's
// accumulator into the output register. With children, the back part
// converts each of the up to three hashes from binary to decimal and
// folds its digits, then does the final mixing once for the node.
// Jobs wait in a short queue, so the front keeps taking requests while the
// back part works or the receiver stalls; in_full rises once it is full.
// Synchronous reset clears the running hash, the queue and the result valid flag.
module oaat_hash_tree_node_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_left_hash,
  input  logic [31:0] in_right_hash,
  input  logic        in_has_left,
  input  logic        in_has_right,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_node_hash
);
  import ohtn_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic q_push, q_full, q_pop, q_empty;

  ohtn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_left_hash (in_left_hash),
    .in_right_hash(in_right_hash),
    .in_has_left  (in_has_left),
    .in_has_right (in_has_right),
    .q_push       (q_push),
    .q_job        (push_job),
    .q_full       (q_full)
  );

  ohtn_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_job(push_job),
    .full  (q_full),
    .pop   (q_pop),
    .rd_job(pop_job),
    .empty (q_empty)
  );

  ohtn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_job        (pop_job),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_node_hash(out_node_hash)
  );

endmodule

[rtl/ohtn_fifo.sv]
// ----------------------------------------------------------------------------
// ohtn_fifo
// Short job queue between the front and the back part.
// ----------------------------------------------------------------------------
module ohtn_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ohtn_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output ohtn_pkg::job_t rd_job,
  output logic          empty
);
  import ohtn_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[rtl/ohtn_front.sv]
// ----------------------------------------------------------------------------
// ohtn_front
// Accepts requests, folds data bytes into the running hash and queues a job
// with the mixed node hash on each finish request.
// ----------------------------------------------------------------------------
module ohtn_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic           in_op,
  input  logic [7:0]     in_data_byte,
  input  logic [31:0]    in_left_hash,
  input  logic [31:0]    in_right_hash,
  input  logic           in_has_left,
  input  logic           in_has_right,
  output logic           q_push,
  output ohtn_pkg::job_t q_job,
  input  logic           q_full
);
  import ohtn_pkg::*;

  logic [HASH_W-1:0] running_r, running_nxt;
  logic              accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && in_op;

  always_comb begin
    q_job.node_h    = oaat_final(running_r);
    q_job.left_h    = in_left_hash;
    q_job.right_h   = in_right_hash;
    q_job.has_left  = in_has_left;
    q_job.has_right = in_has_right;
  end

  always_comb begin
    running_nxt = running_r;
    if (accept) begin
      running_nxt = in_op ? '0 : oaat_mix(running_r, in_data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
    end else begin
      running_r <= running_nxt;
    end
  end

endmodule

[rtl/ohtn_back.sv]
// ----------------------------------------------------------------------------
// ohtn_back
// Takes queued jobs, converts the node and child hashes to decimal, hashes
// the digits (a leaf skips both) and holds the result in the output register.
// ----------------------------------------------------------------------------
module ohtn_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ohtn_pkg::job_t q_job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [31:0]    out_node_hash
);
  import ohtn_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [HASH_W-1:0]    acc_r, acc_nxt;
  logic [HASH_W-1:0]    num_r, num_nxt;
  logic [HASH_W-1:0]    left_r, left_nxt;
  logic [HASH_W-1:0]    right_r, right_nxt;
  logic                 pend_left_r, pend_left_nxt;
  logic                 pend_right_r, pend_right_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic                 started_r, started_nxt;
  logic [HASH_W-1:0]    out_hash_r, out_hash_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           digit;
  logic                 take_digit;

  assign out_empty     = !out_valid_r;
  assign out_node_hash = out_hash_r;
  assign digit         = bcd_r[{idx_r, 2'b00} +: 4];
  // Leading zeros are dropped, but the units digit always counts.
  assign take_digit    = started_r || (digit != 4'd0) || (idx_r == '0);

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    num_nxt        = num_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    pend_left_nxt  = pend_left_r;
    pend_right_nxt = pend_right_r;
    bcd_nxt        = bcd_r;
    bit_cnt_nxt    = bit_cnt_r;
    idx_nxt        = idx_r;
    started_nxt    = started_r;
    out_hash_nxt   = out_hash_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    q_pop          = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          left_nxt       = q_job.left_h;
          right_nxt      = q_job.right_h;
          pend_left_nxt  = q_job.has_left;
          pend_right_nxt = q_job.has_right;
          if (q_job.has_left || q_job.has_right) begin
            acc_nxt     = '0;
            num_nxt     = q_job.node_h;
            bcd_nxt     = '0;
            bit_cnt_nxt = '0;
            state_nxt   = BK_CONV;
          end else begin
            acc_nxt   = q_job.node_h;
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_CONV: begin
        bcd_nxt     = dabble_step(bcd_r, num_r[HASH_W-1]);
        num_nxt     = num_r << 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(HASH_W - 1)) begin
          idx_nxt     = DIG_IDX_W'(DEC_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = BK_FOLD;
        end
      end
      BK_FOLD: begin
        if (take_digit) begin
          acc_nxt     = oaat_mix(acc_r, ASCII_ZERO | {4'b0000, digit});
          started_nxt = 1'b1;
        end
        idx_nxt = idx_r - 1'b1;
        if (idx_r == '0) begin
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          if (pend_left_r) begin
            num_nxt       = left_r;
            pend_left_nxt = 1'b0;
            state_nxt     = BK_CONV;
          end else if (pend_right_r) begin
            num_nxt        = right_r;
            pend_right_nxt = 1'b0;
            state_nxt      = BK_CONV;
          end else begin
            state_nxt = BK_FINAL;
          end
        end
      end
      BK_FINAL: begin
        acc_nxt   = oaat_final(acc_r);
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_hash_nxt  = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_valid_r  <= 1'b0;
      pend_left_r  <= 1'b0;
      pend_right_r <= 1'b0;
      bit_cnt_r    <= '0;
      idx_r        <= '0;
      started_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_left_r  <= pend_left_nxt;
      pend_right_r <= pend_right_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      idx_r        <= idx_nxt;
      started_r    <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    num_r      <= num_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    bcd_r      <= bcd_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule
